/* design/ghbp_pkg.sv */
// Shared types and codes of the global-history branch predictor.
`timescale 1ns / 1ps

package ghbp_pkg;

    // Width of the global history and of the history fields.
    localparam int HIST_W = 16;

    // Request operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Configuration register indexes (word address bit 2).
    localparam logic REG_SPEC = 1'b0;
    localparam logic REG_HLEN = 1'b1;

    // Reset value of the history length register.
    localparam logic [4:0] HLEN_RESET = 5'd12;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // write zero to the next table entry
        logic load;    // capture the request and read the table
        logic commit;  // finish the request and load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // the clearing pass is at its last entry
        logic out_free;    // the result register can take a result this cycle
    } t_dp_status;

endpackage

/* design/ghbp_req_if.sv */
// Request channel of the branch predictor: valid, ready and the request fields.
`timescale 1ns / 1ps

interface ghbp_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        outcome_taken;
    logic [15:0] saved_history;
    logic        squash;

    modport source (output valid, op, outcome_taken, saved_history, squash, input ready);
    modport sink   (input valid, op, outcome_taken, saved_history, squash, output ready);
endinterface

/* design/ghbp_rsp_if.sv */
// Result channel of the branch predictor: valid, ready and the result fields.
`timescale 1ns / 1ps

interface ghbp_rsp_if;
    logic        valid;
    logic        ready;
    logic        predict_taken;
    logic [15:0] history_snapshot;

    modport source (output valid, predict_taken, history_snapshot, input ready);
    modport sink   (input valid, predict_taken, history_snapshot, output ready);
endinterface

/* design/ghbp_ctrl.sv */
// Controller state machine: clearing pass, request capture and result commit.
`timescale 1ns / 1ps

module ghbp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  ghbp_pkg::t_dp_status  i_status,
    output logic                  o_req_ready,
    output ghbp_pkg::t_dp_cmd     o_cmd
);
    import ghbp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd.clear  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Wait here while the previous result is still unclaimed.
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

/* design/ghbp_datapath.sv */
// Datapath: counter table memory, global history, request capture and result register.
`timescale 1ns / 1ps

module ghbp_datapath #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int COUNTER_BITS  = 2,
    parameter int HISTORY_MAX   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ghbp_pkg::t_dp_cmd     i_cmd,
    output ghbp_pkg::t_dp_status  o_status,
    input  logic                  i_spec,
    input  logic [4:0]            i_hist_len,
    input  logic                  i_op,
    input  logic                  i_outcome_taken,
    input  logic [15:0]           i_saved_history,
    input  logic                  i_squash,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_predict_taken,
    output logic [15:0]           o_history_snapshot
);
    import ghbp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

    // Counter table and its registered read port.
    logic [COUNTER_BITS-1:0] mem [TABLE_ENTRIES];
    logic [COUNTER_BITS-1:0] r_rdata;

    // Captured request.
    logic              r_op;
    logic              r_taken;
    logic [HIST_W-1:0] r_saved;
    logic              r_squash;

    logic [HIST_W-1:0] r_hist;
    logic [HIST_W-1:0] n_hist;
    logic [IDX_W-1:0]  r_clr_addr;

    logic              r_out_valid;
    logic              r_pred;
    logic [HIST_W-1:0] r_snap;

    logic [IDX_W-1:0]        raddr;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [COUNTER_BITS-1:0] wdata;
    logic [COUNTER_BITS-1:0] ctr_next;
    logic [4:0]              len_sat;
    logic [HIST_W-1:0]       hmask;
    logic                    pred;

    function automatic logic [HIST_W-1:0] shift_in(input logic [HIST_W-1:0] h,
                                                   input logic b,
                                                   input logic [HIST_W-1:0] m);
        shift_in = {h[HIST_W-2:0], b} & m;
    endfunction

    // Kept history length, limited to the maximum, as a bit mask.
    always_comb begin
        len_sat = (i_hist_len > 5'(HISTORY_MAX)) ? 5'(HISTORY_MAX) : i_hist_len;
        for (int i = 0; i < HIST_W; i++) begin
            hmask[i] = (5'(i) < len_sat);
        end
    end

    assign raddr = (i_op == OP_LOOKUP) ? r_hist[IDX_W-1:0] : i_saved_history[IDX_W-1:0];
    assign pred  = r_rdata[COUNTER_BITS-1];

    always_comb begin
        if (r_taken) begin
            ctr_next = (r_rdata == CTR_MAX) ? r_rdata : r_rdata + COUNTER_BITS'(1);
        end else begin
            ctr_next = (r_rdata == '0) ? r_rdata : r_rdata - COUNTER_BITS'(1);
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_clr_addr;
        wdata = '0;
        if (i_cmd.clear) begin
            we = 1'b1;
        end else if (i_cmd.commit && (r_op == OP_UPDATE)) begin
            we    = 1'b1;
            waddr = r_saved[IDX_W-1:0];
            wdata = ctr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.load) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_taken  <= i_outcome_taken;
            r_saved  <= i_saved_history;
            r_squash <= i_squash;
        end
    end

    always_comb begin
        n_hist = r_hist;
        if (r_op == OP_LOOKUP) begin
            if (i_spec) begin
                n_hist = shift_in(r_hist, pred, hmask);
            end
        end else if (!i_spec) begin
            n_hist = shift_in(r_hist, r_taken, hmask);
        end else if (r_squash) begin
            n_hist = shift_in(r_saved, r_taken, hmask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.commit) begin
                r_hist      <= n_hist;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_pred <= (r_op == OP_LOOKUP) ? pred : 1'b0;
            r_snap <= (r_op == OP_LOOKUP) ? r_hist : '0;
        end
    end

    assign o_status.clear_last = (r_clr_addr == '1);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_predict_taken    = r_pred;
    assign o_history_snapshot = r_snap;

endmodule

/* design/global_history_branch_predictor.sv */
// Top level of the global-history two-level branch predictor.
`timescale 1ns / 1ps
//
// Requests arrive on i_req (valid/ready). A lookup (op = 0) returns the top bit of
// the counter selected by the low global-history bits as predict_taken, together
// with the history as it stood before the lookup; in speculative mode the prediction
// is also shifted into the history. An update (op = 1) moves the counter selected by
// saved_history towards outcome_taken and then maintains the history (shifted in
// non-speculative mode, restored and shifted on a squash in speculative mode); its
// result carries zeros. Each request yields exactly one result on o_rsp.
// A request first reads the counter table through its registered read port, then
// writes the counter back and loads the result register. Requests are taken one at
// a time: a new request is accepted only after the previous one has finished.
// A result waiting in the result register does not block acceptance of the next
// request; if the receiver stalls, that request waits, before its write-back, until the
// result register is free.
// After reset the counter table is cleared one entry per cycle, and no request is
// accepted while the clearing pass runs. The APB port holds
// speculative_update (address 0) and history_length (address 4), and may be written
// at any time, but only while the block is idle does a write have a defined effect.

module global_history_branch_predictor #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int COUNTER_BITS  = 2,
    parameter int HISTORY_MAX   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ghbp_req_if.sink    i_req,
    ghbp_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ghbp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_ready;

    // Configuration registers.
    logic       r_spec;
    logic [4:0] r_hlen;
    logic       cfg_wr;

    // Registers are decoded on address bit 2; every write completes in its access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec <= 1'b0;
            r_hlen <= HLEN_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SPEC) begin
                r_spec <= pwdata[0];
            end else begin
                r_hlen <= pwdata[4:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HLEN) ? {27'd0, r_hlen} : {31'd0, r_spec};

    // The controller sequences the clearing pass and each request.
    ghbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (w_ready),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_ready;

    // The datapath holds the table, the history and the result register.
    ghbp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNTER_BITS  (COUNTER_BITS),
        .HISTORY_MAX   (HISTORY_MAX)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_spec             (r_spec),
        .i_hist_len         (r_hlen),
        .i_op               (i_req.op),
        .i_outcome_taken    (i_req.outcome_taken),
        .i_saved_history    (i_req.saved_history),
        .i_squash           (i_req.squash),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_predict_taken    (o_rsp.predict_taken),
        .o_history_snapshot (o_rsp.history_snapshot)
    );

    // Only one request is in flight: an accepted request drops ready the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    // A committed request always presents a result in the following cycle.
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_rsp.valid)
        else $error("commit without result");

    // No request is taken while the counter table is being cleared.
    a_no_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> !i_req.ready)
        else $error("request accepted during clearing pass");

endmodule
